### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks used by the prime list datapath.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Check that a condition never holds at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`endif

### hdl/plt_pkg.sv
// ---------------------------------------------------------------------------
// plt_pkg
// Widths, constants and controller/datapath command and status types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package plt_pkg;

    localparam int VAL_W = 9;
    localparam int CNT_W = 4;

    localparam logic [VAL_W-1:0] LIMIT_CAP   = 9'd311;
    localparam logic [VAL_W-1:0] FIRST_PRIME = 9'd2;

    typedef logic [VAL_W-1:0] val_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_lim;   // capture capped limit, reset candidate, divisor and pending
        logic start_div;  // launch remainder of candidate by divisor
        logic inc_div;    // advance divisor
        logic inc_cand;   // advance candidate, restart divisor at two
        logic take_pend;  // park candidate as pending prime
        logic out_err;    // load error beat into output register
        logic out_pend;   // load pending prime into output register
        logic out_last;   // last flag for out_pend
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic lim_err;      // incoming limit below two
        logic div_ge_cand;  // divisor reached candidate: no factor found
        logic div_done;     // remainder ready
        logic rem_zero;     // divisor divides candidate
        logic cand_at_lim;  // candidate equals limit
        logic pend_valid;   // a prime waits in the pending register
        logic out_free;     // output register can take a beat
    } dp_stat_t;

    // Divider status
    typedef struct packed {
        logic done;
        logic rem_zero;
    } div_stat_t;

endpackage

### hdl/plt_div.sv
// ---------------------------------------------------------------------------
// plt_div
// Restoring serial remainder unit: one dividend bit per cycle, MSB first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module plt_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  plt_pkg::val_t       dividend,
    input  plt_pkg::val_t       divisor,
    output plt_pkg::div_stat_t  stat
);
    import plt_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    val_t             dvd_reg, dvd_next;
    val_t             dsr_reg, dsr_next;
    val_t             rem_reg, rem_next;
    logic [VAL_W:0]   trial;

    // Shift next dividend bit into the partial remainder
    assign trial = {rem_reg, dvd_reg[VAL_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            // Subtract when the divisor fits, else keep the shifted value
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = VAL_W'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = trial[VAL_W-1:0];
            end
            dvd_next = {dvd_reg[VAL_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VAL_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == '0);

endmodule

### hdl/plt_dp.sv
// ---------------------------------------------------------------------------
// plt_dp
// Datapath: limit, candidate, divisor, pending prime and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plt_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  plt_pkg::dp_cmd_t   cmd,
    output plt_pkg::dp_stat_t  stat,
    input  plt_pkg::val_t      s_limit,
    output logic               m_valid,
    input  logic               m_ready,
    output plt_pkg::val_t      m_prime_value,
    output logic               m_last,
    output logic               m_error
);
    import plt_pkg::*;

    val_t      lim_reg, lim_next;
    val_t      cand_reg, cand_next;
    val_t      div_reg, div_next;
    val_t      pend_reg, pend_next;
    logic      pend_valid_reg, pend_valid_next;
    logic      m_valid_reg, m_valid_next;
    val_t      m_prime_value_reg, m_prime_value_next;
    logic      m_last_reg, m_last_next;
    logic      m_error_reg, m_error_next;
    div_stat_t div_stat;

    plt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_div),
        .dividend (cand_reg),
        .divisor  (div_reg),
        .stat     (div_stat)
    );

    // Candidate, divisor and pending prime
    always_comb begin
        lim_next        = lim_reg;
        cand_next       = cand_reg;
        div_next        = div_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (cmd.load_lim) begin
            lim_next        = (s_limit > LIMIT_CAP) ? LIMIT_CAP : s_limit;
            cand_next       = FIRST_PRIME;
            div_next        = FIRST_PRIME;
            pend_valid_next = 1'b0;
        end
        if (cmd.inc_cand) begin
            cand_next = cand_reg + 1'b1;
            div_next  = FIRST_PRIME;
        end
        if (cmd.inc_div) begin
            div_next = div_reg + 1'b1;
        end
        if (cmd.take_pend) begin
            pend_next       = cand_reg;
            pend_valid_next = 1'b1;
        end
    end

    // Output register: load a beat, drop it once taken
    always_comb begin
        m_valid_next       = m_valid_reg;
        m_prime_value_next = m_prime_value_reg;
        m_last_next        = m_last_reg;
        m_error_next       = m_error_reg;
        if (cmd.out_err) begin
            m_valid_next       = 1'b1;
            m_prime_value_next = '0;
            m_last_next        = 1'b1;
            m_error_next       = 1'b1;
        end else if (cmd.out_pend) begin
            m_valid_next       = 1'b1;
            m_prime_value_next = pend_reg;
            m_last_next        = cmd.out_last;
            m_error_next       = 1'b0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        lim_reg           <= lim_next;
        cand_reg          <= cand_next;
        div_reg           <= div_next;
        pend_reg          <= pend_next;
        m_prime_value_reg <= m_prime_value_next;
        m_last_reg        <= m_last_next;
        m_error_reg       <= m_error_next;
    end

    assign stat.lim_err     = (s_limit < FIRST_PRIME);
    assign stat.div_ge_cand = (div_reg >= cand_reg);
    assign stat.div_done    = div_stat.done;
    assign stat.rem_zero    = div_stat.rem_zero;
    assign stat.cand_at_lim = (cand_reg == lim_reg);
    assign stat.pend_valid  = pend_valid_reg;
    assign stat.out_free    = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_prime_value = m_prime_value_reg;
    assign m_last        = m_last_reg;
    assign m_error       = m_error_reg;

    // Never emit an empty pending slot
    `ASSERT_CLK(a_pend_filled, aclk, aresetn, cmd.out_pend |-> pend_valid_reg)
    // Candidate never runs past the limit
    `ASSERT_CLK(a_cand_bound, aclk, aresetn, cmd.inc_cand |-> (cand_reg != lim_reg))
    // Error beat is always a lone last beat with zero value
    `ASSERT_CLK(a_err_beat, aclk, aresetn,
        (m_valid_reg && m_error_reg) |-> (m_last_reg && (m_prime_value_reg == '0)))
    // Prime beats carry a value of at least two
    `ASSERT_CLK(a_prime_min, aclk, aresetn,
        (m_valid_reg && !m_error_reg) |-> (m_prime_value_reg >= FIRST_PRIME))

endmodule

### hdl/plt_ctrl.sv
// ---------------------------------------------------------------------------
// plt_ctrl
// Controller: walks candidates and divisors, sequences output beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module plt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  plt_pkg::dp_stat_t  stat,
    output plt_pkg::dp_cmd_t   cmd
);
    import plt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ERR   = 3'd1;
    localparam logic [2:0] S_TEST  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_PRIME = 3'd4;
    localparam logic [2:0] S_NEXT  = 3'd5;
    localparam logic [2:0] S_FINAL = 3'd6;

    logic [2:0] state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_lim = 1'b1;
                    state_next   = stat.lim_err ? S_ERR : S_TEST;
                end
            end
            S_ERR: begin
                if (stat.out_free) begin
                    cmd.out_err = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            // Divisor reached candidate without a factor: prime; else start a trial division
            S_TEST: begin
                if (stat.div_ge_cand) begin
                    state_next = S_PRIME;
                end else begin
                    cmd.start_div = 1'b1;
                    state_next    = S_WAIT;
                end
            end
            S_WAIT: begin
                if (stat.div_done) begin
                    if (stat.rem_zero) begin
                        state_next = S_NEXT;
                    end else begin
                        cmd.inc_div = 1'b1;
                        state_next  = S_TEST;
                    end
                end
            end
            // Flush the previous prime (not last), park this one
            S_PRIME: begin
                if (!stat.pend_valid || stat.out_free) begin
                    cmd.out_pend  = stat.pend_valid;
                    cmd.take_pend = 1'b1;
                    state_next    = S_NEXT;
                end
            end
            S_NEXT: begin
                if (stat.cand_at_lim) begin
                    state_next = S_FINAL;
                end else begin
                    cmd.inc_cand = 1'b1;
                    state_next   = S_TEST;
                end
            end
            S_FINAL: begin
                if (stat.out_free) begin
                    cmd.out_pend = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/prime_list_trial_division_top.sv
// ---------------------------------------------------------------------------
// prime_list_trial_division_top
// Emits every prime from 2 up to a given limit, found by trial division.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready/s_limit): one beat per limit. Limits above
//   311 are treated as 311. s_ready is high only while no run is in progress.
//   Result channel (m_valid/m_ready/m_prime_value/m_last/m_error): one beat
//   per prime, ascending, m_last on the final beat. A limit below 2 gives a
//   single beat with m_error and m_last set and a zero value.
// Sequencing:
//   Each trial division passes S_TEST, then runs in the shared serial remainder
//   unit (nine dividend bits, one per cycle, then done); a composite candidate
//   then passes S_NEXT, and a prime passes S_TEST, S_PRIME and S_NEXT.
//   A prime is held back until the next prime or the end of the run is
//   found, so its beat appears only then. An error beat goes from S_ERR
//   into the output register once its limit is accepted and the output
//   register is free.
// Reset and stall:
//   aresetn (synchronous, active low) aborts any run and drops the output
//   beat. A stalled receiver holds the output register; the search pauses
//   when a new beat is ready and the register is still full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_list_trial_division_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  plt_pkg::val_t       s_limit,
    output logic                m_valid,
    input  logic                m_ready,
    output plt_pkg::val_t       m_prime_value,
    output logic                m_last,
    output logic                m_error
);
    import plt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    plt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    plt_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_limit       (s_limit),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_prime_value (m_prime_value),
        .m_last        (m_last),
        .m_error       (m_error)
    );

endmodule

### tb/prime_list_trial_division_top_test.sv
// ---------------------------------------------------------------------------
// prime_list_trial_division_top_test
// Self-checking bench: sends limits, predicts the ascending prime list of
// each one by trial division and compares every result beat in order.
// Covers error limits, the cap, bursts and gaps on the input, stalls on the
// output and one long output hold.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_list_trial_division_top_test;

    import plt_pkg::*;

    // One expected result beat
    typedef struct {
        val_t value;
        logic last;
        logic error;
    } prime_beat_t;

    // Holds the predicted prime beats and checks the result stream
    class prime_beat_board;
        prime_beat_t expected_beats[$];
        int          errors;
        int          limits_seen;
        int          error_limits;
        int          beats_checked;

        task report(input string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        // Predict every beat of one accepted limit
        function void note_limit(input val_t lim);
            int unsigned top;
            int unsigned cand;
            int unsigned d;
            bit          is_p;
            prime_beat_t b;
            limits_seen++;
            if (lim < FIRST_PRIME) begin
                b.value = '0;
                b.last  = 1'b1;
                b.error = 1'b1;
                expected_beats.push_back(b);
                error_limits++;
                return;
            end
            top = (lim > LIMIT_CAP) ? LIMIT_CAP : lim;
            for (cand = FIRST_PRIME; cand <= top; cand++) begin
                is_p = 1'b1;
                for (d = FIRST_PRIME; d < cand; d++) begin
                    if (cand % d == 0) begin
                        is_p = 1'b0;
                        break;
                    end
                end
                if (is_p) begin
                    b.value = val_t'(cand);
                    b.last  = 1'b0;
                    b.error = 1'b0;
                    expected_beats.push_back(b);
                end
            end
            expected_beats[expected_beats.size() - 1].last = 1'b1;
        endfunction

        // Compare one result beat with the oldest prediction
        task check_beat(input val_t value, input logic last, input logic error);
            prime_beat_t want;
            if (expected_beats.size() == 0) begin
                report($sformatf("unexpected beat value=%0d last=%0b error=%0b",
                                 value, last, error));
                return;
            end
            want = expected_beats.pop_front();
            beats_checked++;
            if (value !== want.value)
                report($sformatf("prime_value %0d, want %0d", value, want.value));
            if (last !== want.last)
                report($sformatf("last %0b, want %0b (value %0d)", last, want.last,
                                 want.value));
            if (error !== want.error)
                report($sformatf("error %0b, want %0b (value %0d)", error, want.error,
                                 want.value));
        endtask

        function int outstanding();
            return expected_beats.size();
        endfunction
    endclass

    localparam int RANDOM_LIMITS = 100;
    localparam int LONG_HOLD     = 600;
    localparam int DRAIN_CYCLES  = 60;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    val_t s_limit;
    logic m_valid;
    logic m_ready;
    val_t m_prime_value;
    logic m_last;
    logic m_error;

    prime_beat_board sb = new();

    bit random_phase;
    bit held_once;
    int hold_left;
    int burst_left;

    prime_list_trial_division_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_limit       (s_limit),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_prime_value (m_prime_value),
        .m_last        (m_last),
        .m_error       (m_error)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Offer one limit from a falling edge and hold it until accepted
    task automatic send_limit(input val_t lim);
        s_valid = 1'b1;
        s_limit = lim;
        do @(posedge aclk); while (!s_ready);
        sb.note_limit(lim);
        @(negedge aclk);
    endtask

    // Send a limit, then idle for a gap when the current burst runs out
    task automatic send_in_bursts(input val_t lim);
        int gap;
        send_limit(lim);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    // Mostly short runs; errors and mid sizes now and then
    function automatic val_t pick_limit();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return val_t'($urandom_range(0, 1));
        else if (r < 78)
            return val_t'($urandom_range(2, 40));
        else
            return val_t'($urandom_range(41, 100));
    endfunction

    // Receiver: stall modes that change now and then, plus one long hold
    initial begin
        int mode;
        int mode_left;
        int phase;
        mode = 0;
        mode_left = 0;
        phase = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held_once && random_phase && s_valid && !s_ready && m_valid) begin
                held_once = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 128);
            end
            mode_left--;
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                case (mode)
                    0: m_ready = 1'b1;
                    1: m_ready = 1'($urandom_range(0, 1));
                    2: m_ready = (phase % 4 == 0);
                    default: m_ready = (phase % 4 != 0);
                endcase
            end
        end
    end

    // Check every accepted result beat
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_beat(m_prime_value, m_last, m_error);
    end

    // Hard stop for a hung run
    initial begin
        #20_000_000;
        $display("prime_list_trial_division_top verification failed");
        $finish;
    end

    // Reset, directed limits, random limits, drain, verdict
    initial begin
        val_t directed[$];
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_limit = '0;
        random_phase = 1'b0;
        burst_left = 1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Below two, two itself, small primes and composites, all-ones above cap
        directed = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9,
                     9'd11, 9'd12, 9'd13, 9'd23, 9'd24, 9'd31, 9'd64, 9'd127,
                     LIMIT_CAP, 9'd511, 9'd0, 9'd2};
        foreach (directed[i])
            send_in_bursts(directed[i]);

        random_phase = 1'b1;
        repeat (RANDOM_LIMITS)
            send_in_bursts(pick_limit());
        s_valid = 1'b0;

        // Drain, then watch for stray beats
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d limits (%0d below two) and %0d checked beats.",
                 sb.limits_seen, sb.error_limits, sb.beats_checked);
        $display("Long output hold of %0d cycles applied: %0b.", LONG_HOLD, held_once);
        if (sb.errors == 0) begin
            $display("prime_list_trial_division_top verification clean");
        end else begin
            $display("prime_list_trial_division_top verification failed");
        end
        $finish;
    end

endmodule
